// ----- hdl/rro_pkg.sv -----
// shared types and constants of the rounded rectangle outline overlay
package rro_pkg;

	localparam int COORD_BITS = 13;
	localparam int CH_W       = 8;
	localparam int COLOR_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	// signed working width for edges, clamped centers and deltas
	localparam int POS_W      = COORD_BITS + 3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [CH_W-1:0] chan_t;

	localparam chan_t RADIUS_RST  = 8'd10;
	localparam chan_t STROKE_RST  = 8'd3;
	localparam logic [COLOR_W-1:0] COLOR_RST = 32'hE031_31FF;
	localparam chan_t DIM_RST     = 8'd215;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CORNER_A_X    = 3'd0,
		CFG_CORNER_A_Y    = 3'd1,
		CFG_CORNER_B_X    = 3'd2,
		CFG_CORNER_B_Y    = 3'd3,
		CFG_CORNER_RAD    = 3'd4,
		CFG_OUTLINE_WIDTH = 3'd5,
		CFG_OUTLINE_CLR   = 3'd6,
		CFG_DIM_FACTOR    = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		coord_t              corner_a_x;
		coord_t              corner_a_y;
		coord_t              corner_b_x;
		coord_t              corner_b_y;
		chan_t               corner_radius;
		chan_t               outline_width;
		logic [COLOR_W-1:0]  outline_color;
		chan_t               dim_factor;
	} cfg_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		chan_t  in_red;
		chan_t  in_green;
		chan_t  in_blue;
		chan_t  in_alpha;
		logic   overlay_enable;
	} pix_in_t;

	typedef struct packed {
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
		chan_t out_alpha;
	} pix_out_t;

	// load strobes of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_ld_t;

endpackage

// ----- hdl/rro_cfg.sv -----
// configuration register file of the overlay
module rro_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rro_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rro_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output rro_pkg::cfg_t                    cfg
);

	rro_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.corner_a_x    <= '0;
			cfg_q.corner_a_y    <= '0;
			cfg_q.corner_b_x    <= '0;
			cfg_q.corner_b_y    <= '0;
			cfg_q.corner_radius <= rro_pkg::RADIUS_RST;
			cfg_q.outline_width <= rro_pkg::STROKE_RST;
			cfg_q.outline_color <= rro_pkg::COLOR_RST;
			cfg_q.dim_factor    <= rro_pkg::DIM_RST;
		end else if (cfg_we) begin
			unique case (rro_pkg::cfg_idx_e'(cfg_idx))
				rro_pkg::CFG_CORNER_A_X: begin
					cfg_q.corner_a_x <= cfg_wdata[rro_pkg::COORD_BITS-1:0];
				end
				rro_pkg::CFG_CORNER_A_Y: begin
					cfg_q.corner_a_y <= cfg_wdata[rro_pkg::COORD_BITS-1:0];
				end
				rro_pkg::CFG_CORNER_B_X: begin
					cfg_q.corner_b_x <= cfg_wdata[rro_pkg::COORD_BITS-1:0];
				end
				rro_pkg::CFG_CORNER_B_Y: begin
					cfg_q.corner_b_y <= cfg_wdata[rro_pkg::COORD_BITS-1:0];
				end
				rro_pkg::CFG_CORNER_RAD: begin
					cfg_q.corner_radius <= cfg_wdata[rro_pkg::CH_W-1:0];
				end
				rro_pkg::CFG_OUTLINE_WIDTH: begin
					cfg_q.outline_width <= cfg_wdata[rro_pkg::CH_W-1:0];
				end
				rro_pkg::CFG_OUTLINE_CLR: begin
					cfg_q.outline_color <= cfg_wdata[rro_pkg::COLOR_W-1:0];
				end
				rro_pkg::CFG_DIM_FACTOR: begin
					cfg_q.dim_factor <= cfg_wdata[rro_pkg::CH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/rro_pipe_ctrl.sv -----
// valid bits and stall chain of the four stage pipeline
module rro_pipe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output rro_pkg::stage_ld_t    ld
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		rdy4 = !v_s4 || res_ready;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign ld.s1     = rdy1;
	assign ld.s2     = rdy2;
	assign ld.s3     = rdy3;
	assign ld.s4     = rdy4;
	assign pix_ready = rdy1;
	assign res_valid = v_s4;

endmodule

// ----- hdl/rro_dim.sv -----
// color dimming: channel * dim / 255, three stages
module rro_dim (
	input  logic                clk,
	input  rro_pkg::stage_ld_t  ld,
	input  rro_pkg::pix_in_t    pix,
	input  rro_pkg::chan_t      dim_factor,
	output rro_pkg::pix_out_t   dim_s3
);

	localparam int PROD_W = 2 * rro_pkg::CH_W;

	logic [PROD_W-1:0] pr_s1, pg_s1, pb_s1;
	rro_pkg::chan_t    a_s1;
	rro_pkg::pix_out_t q_s2;

	// exact x / 255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
	function automatic rro_pkg::chan_t div255(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] t;
		t = (PROD_W+1)'(p) + (PROD_W+1)'(p[PROD_W-1:rro_pkg::CH_W]) + (PROD_W+1)'(1);
		return t[PROD_W-1:rro_pkg::CH_W];
	endfunction

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			pr_s1 <= PROD_W'(pix.in_red) * PROD_W'(dim_factor);
			pg_s1 <= PROD_W'(pix.in_green) * PROD_W'(dim_factor);
			pb_s1 <= PROD_W'(pix.in_blue) * PROD_W'(dim_factor);
			a_s1  <= pix.in_alpha;
		end
		if (ld.s2) begin
			q_s2.out_red   <= div255(pr_s1);
			q_s2.out_green <= div255(pg_s1);
			q_s2.out_blue  <= div255(pb_s1);
			q_s2.out_alpha <= a_s1;
		end
		if (ld.s3) begin
			dim_s3 <= q_s2;
		end
	end

endmodule

// ----- hdl/rro_shape.sv -----
// outer / inner rounded rectangle test, three stages plus final compare
module rro_shape (
	input  logic                clk,
	input  rro_pkg::stage_ld_t  ld,
	input  rro_pkg::pix_in_t    pix,
	input  rro_pkg::cfg_t       cfg,
	output logic                hit
);

	localparam int POS_W = rro_pkg::POS_W;
	localparam int EXT_C = POS_W - rro_pkg::COORD_BITS;
	localparam int EXT_R = POS_W - rro_pkg::CH_W;
	// deltas stay within +-2^(COORD_BITS+1)
	localparam int SQ_W  = 2 * (rro_pkg::COORD_BITS + 1);
	localparam int RR_W  = 2 * rro_pkg::CH_W;

	// delta from the point to its clamped corner center on one axis
	function automatic rro_pkg::pos_t axis_delta(
		input rro_pkg::pos_t p,
		input rro_pkg::pos_t e_lo,
		input rro_pkg::pos_t e_hi,
		input rro_pkg::pos_t r
	);
		rro_pkg::pos_t lo, hi, c;
		lo = e_lo + r;
		hi = e_hi - r;
		if (p < lo) c = lo;
		else if (p >= hi) c = hi - rro_pkg::pos_t'(1);
		else c = p;
		return p - c;
	endfunction

	// stage 1: box edges, inset edges, box membership
	rro_pkg::coord_t left, right, top, bottom;
	rro_pkg::pos_t   s_ext, r_ext;
	logic            inbox;

	rro_pkg::pos_t x_s1, y_s1;
	rro_pkg::pos_t olx_s1, ohx_s1, oly_s1, ohy_s1;
	rro_pkg::pos_t ilx_s1, ihx_s1, ily_s1, ihy_s1;
	logic          en_s1;

	always_comb begin
		left   = (cfg.corner_a_x < cfg.corner_b_x) ? cfg.corner_a_x : cfg.corner_b_x;
		right  = (cfg.corner_a_x > cfg.corner_b_x) ? cfg.corner_a_x : cfg.corner_b_x;
		top    = (cfg.corner_a_y < cfg.corner_b_y) ? cfg.corner_a_y : cfg.corner_b_y;
		bottom = (cfg.corner_a_y > cfg.corner_b_y) ? cfg.corner_a_y : cfg.corner_b_y;
		s_ext  = {{EXT_R{1'b0}}, cfg.outline_width};
		r_ext  = {{EXT_R{1'b0}}, cfg.corner_radius};
		inbox  = pix.overlay_enable
			&& (pix.pixel_x >= left) && (pix.pixel_x <= right)
			&& (pix.pixel_y >= top) && (pix.pixel_y <= bottom);
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			x_s1   <= {{EXT_C{1'b0}}, pix.pixel_x};
			y_s1   <= {{EXT_C{1'b0}}, pix.pixel_y};
			olx_s1 <= {{EXT_C{1'b0}}, left};
			ohx_s1 <= {{EXT_C{1'b0}}, right};
			oly_s1 <= {{EXT_C{1'b0}}, top};
			ohy_s1 <= {{EXT_C{1'b0}}, bottom};
			ilx_s1 <= rro_pkg::pos_t'({{EXT_C{1'b0}}, left}) + s_ext;
			ihx_s1 <= rro_pkg::pos_t'({{EXT_C{1'b0}}, right}) - s_ext;
			ily_s1 <= rro_pkg::pos_t'({{EXT_C{1'b0}}, top}) + s_ext;
			ihy_s1 <= rro_pkg::pos_t'({{EXT_C{1'b0}}, bottom}) - s_ext;
			en_s1  <= inbox;
		end
	end

	// stage 2: clamp to corner centers, deltas
	rro_pkg::pos_t dxo_s2, dyo_s2, dxi_s2, dyi_s2;
	logic          en_s2;

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			dxo_s2 <= axis_delta(x_s1, olx_s1, ohx_s1, r_ext);
			dyo_s2 <= axis_delta(y_s1, oly_s1, ohy_s1, r_ext);
			dxi_s2 <= axis_delta(x_s1, ilx_s1, ihx_s1, r_ext);
			dyi_s2 <= axis_delta(y_s1, ily_s1, ihy_s1, r_ext);
			en_s2  <= en_s1;
		end
	end

	// stage 3: squares
	logic signed [2*POS_W-1:0] mxo, myo, mxi, myi;
	logic [SQ_W-1:0]           sxo_s3, syo_s3, sxi_s3, syi_s3;
	logic [RR_W-1:0]           rr_s3;
	logic                      en_s3;

	always_comb begin
		mxo = dxo_s2 * dxo_s2;
		myo = dyo_s2 * dyo_s2;
		mxi = dxi_s2 * dxi_s2;
		myi = dyi_s2 * dyi_s2;
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			sxo_s3 <= mxo[SQ_W-1:0];
			syo_s3 <= myo[SQ_W-1:0];
			sxi_s3 <= mxi[SQ_W-1:0];
			syi_s3 <= myi[SQ_W-1:0];
			rr_s3  <= RR_W'(cfg.corner_radius) * RR_W'(cfg.corner_radius);
			en_s3  <= en_s2;
		end
	end

	// distance compare, feeds the output register
	logic [SQ_W:0] sum_o, sum_i, rr_ext;
	logic          in_outer, in_inner;

	always_comb begin
		sum_o    = (SQ_W+1)'(sxo_s3) + (SQ_W+1)'(syo_s3);
		sum_i    = (SQ_W+1)'(sxi_s3) + (SQ_W+1)'(syi_s3);
		rr_ext   = (SQ_W+1)'(rr_s3);
		in_outer = sum_o <= rr_ext;
		in_inner = sum_i <= rr_ext;
		hit      = en_s3 && in_outer && !in_inner;
	end

endmodule

// ----- hdl/rounded_rect_outline_overlay_top.sv -----
// top level of the rounded rectangle outline overlay
//
// one pixel beat in, one pixel beat out. the block takes a pixel on every
// clock while the result side keeps up, and each pixel then goes through the
// stages in order: stage one does the corner min/max, stroke inset
// and the 8x8 dim products, stage two clamps to the corner-circle centers and
// divides by 255, stage three squares the deltas, stage four is the output
// register that selects outline color or dimmed pixel. when the result side
// stalls, the stages fill up behind the output register and the pixel side
// stops only once all four are full. configuration registers are read live by
// every stage, so write them only while no pixel is in flight.
module rounded_rect_outline_overlay_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel channel
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  rro_pkg::pix_in_t                 pix_data,
	// result channel
	output logic                             res_valid,
	input  logic                             res_ready,
	output rro_pkg::pix_out_t                res_data,
	// register write port
	input  logic                             cfg_we,
	input  logic [rro_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rro_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	rro_pkg::cfg_t      cfg;
	rro_pkg::stage_ld_t ld;
	rro_pkg::pix_out_t  dim_s3;
	rro_pkg::pix_out_t  res_s4;
	logic               hit;

	rro_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// valid bits and per-stage load strobes
	rro_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ld        (ld)
	);

	// dimmed pixel, ready at the end of stage three
	rro_dim u_dim (
		.clk        (clk),
		.ld         (ld),
		.pix        (pix_data),
		.dim_factor (cfg.dim_factor),
		.dim_s3     (dim_s3)
	);

	// outline hit, ready from the stage three registers
	rro_shape u_shape (
		.clk (clk),
		.ld  (ld),
		.pix (pix_data),
		.cfg (cfg),
		.hit (hit)
	);

	// output register: outline color replaces the whole pixel on a hit
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			if (hit) begin
				res_s4.out_red   <= cfg.outline_color[31:24];
				res_s4.out_green <= cfg.outline_color[23:16];
				res_s4.out_blue  <= cfg.outline_color[15:8];
				res_s4.out_alpha <= cfg.outline_color[7:0];
			end else begin
				res_s4 <= dim_s3;
			end
		end
	end

	assign res_data = res_s4;

endmodule

// ----- hdl/rro_checker.sv -----
// port checker for the overlay, bound to the top level
module rro_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_ready,
	input logic              res_valid,
	input logic              res_ready,
	input rro_pkg::pix_out_t res_data
);

	// a held result beat keeps its data
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
	else $error("result beat changed while stalled");

	// an open result side never stalls the pixel side
	assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> pix_ready)
	else $error("pixel side stalled while result side ready");

	// from an empty output, a new result beat must trace back to an accepted pixel beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && pix_ready, 4))
	else $error("result beat without matching pixel beat");

endmodule

bind rounded_rect_outline_overlay_top rro_checker u_rro_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
